// File: design/im2row_pkg.sv
package im2row_pkg;

	localparam int MAX_TAPS_DEFAULT   = 64;
	localparam int COORD_BITS_DEFAULT = 12;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 24;

	localparam logic [CFG_INDEX_W-1:0] REG_INPUT_SIZE      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FILTER_SIZE     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PADDING_OFFSETS = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_PAIR     = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_DILATION_PAIR   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_TAP_ORDER       = 3'd5;

	localparam logic [23:0] INPUT_SIZE_RST    = 24'd4097;
	localparam logic [15:0] FILTER_SIZE_RST   = 16'd257;
	localparam logic [15:0] PADDING_RST       = 16'd0;
	localparam logic [15:0] STRIDE_RST        = 16'd257;
	localparam logic [15:0] DILATION_RST      = 16'd257;
	localparam logic        TAP_ORDER_DIRECT  = 1'b1;

	typedef struct packed {
		logic [7:0]  batch_index;
		logic [11:0] out_row;
		logic [11:0] out_col;
	} tile_req_t;

	typedef struct packed {
		logic [7:0]  src_batch;
		logic [11:0] src_row;
		logic [11:0] src_col;
		logic        is_padding;
		logic [5:0]  tap_index;
		logic [23:0] tile_index;
		logic        last_tap;
	} tap_addr_t;

endpackage

// File: design/im2row_tap_address_generator.sv
// Channel  Signals                          Direction  Moves
// -------  -------------------------------  ---------  --------------------------------
// in       in_valid/in_ready/in_data        input      one tile item (batch, row, col)
// out      out_valid/out_ready/out_data     output     one tap address item per tap
// cfg      cfg_valid/cfg_ready/cfg_index/   input      one register write, always taken
//          cfg_data
//
// A tile is taken only when the sequencer is idle. A setup phase follows, in which one
// shared 12x8 multiplier forms out_row*stride, out_col*stride and the flipped start offsets.
// Then one tap item per cycle unless the output stalls: min(fh*fw, MAX_TAPS) items per tile,
// or none when the filter is empty. A stalled output register holds the tap walk in place.
// Reset clears the configuration to its defaults, the tile counter to zero and all valids.
module im2row_tap_address_generator import im2row_pkg::*; #(
	parameter int MAX_TAPS   = MAX_TAPS_DEFAULT,
	parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  tile_req_t              in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output tap_addr_t              out_data,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int CW    = (COORD_BITS < 12) ? COORD_BITS : 12;
	localparam int AW    = 22;
	localparam int CNT_W = $clog2(MAX_TAPS + 1);
	localparam logic [11:0] CMASK = 12'((1 << CW) - 1);

	typedef enum logic [1:0] {S_IDLE, S_SETUP, S_TAPS} state_t;

	state_t state_q;

	logic [23:0] input_size_q;
	logic [15:0] filter_size_q;
	logic [15:0] padding_q;
	logic [15:0] stride_q;
	logic [15:0] dilation_q;
	logic        tap_order_q;
	logic [23:0] tile_cnt_q;

	logic [7:0]  batch_q;
	logic [11:0] orow_q;
	logic [11:0] ocol_q;
	logic [23:0] tile_q;
	logic [2:0]  step_q;
	logic [19:0] prod_q;
	logic signed [AW-1:0] x_q;
	logic signed [AW-1:0] y_q;
	logic signed [AW-1:0] colb_q;
	logic [7:0]  i_q;
	logic [7:0]  j_q;
	logic [CNT_W-1:0] cnt_q;
	logic        out_valid_q;
	tap_addr_t   out_q;

	logic [7:0]  fh, fw, sr, sc, dr, dc;
	logic [11:0] ih, iw;
	logic [11:0] mul_a;
	logic [7:0]  mul_b;
	logic [19:0] mul_p;
	logic signed [AW-1:0] prod_s;
	logic signed [AW-1:0] dr_s, dc_s;
	logic        direct;
	logic        in_image;
	logic        last;
	logic        emit;
	logic        in_acc;

	assign ih     = input_size_q[11:0];
	assign iw     = input_size_q[23:12];
	assign fh     = filter_size_q[7:0];
	assign fw     = filter_size_q[15:8];
	assign sr     = stride_q[7:0];
	assign sc     = stride_q[15:8];
	assign dr     = dilation_q[7:0];
	assign dc     = dilation_q[15:8];
	assign direct = tap_order_q;
	assign dr_s   = $signed(AW'(dr));
	assign dc_s   = $signed(AW'(dc));
	assign prod_s = $signed(AW'(prod_q));

	always_comb begin
		case (step_q)
			3'd0: begin
				mul_a = orow_q;
				mul_b = sr;
			end
			3'd1: begin
				mul_a = ocol_q;
				mul_b = sc;
			end
			3'd2: begin
				mul_a = 12'(fh - 8'd1);
				mul_b = dr;
			end
			3'd3: begin
				mul_a = 12'(fw - 8'd1);
				mul_b = dc;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign in_image = (x_q >= 0) && (x_q < $signed(AW'(ih)))
		&& (y_q >= 0) && (y_q < $signed(AW'(iw)));
	assign last   = (cnt_q == CNT_W'(MAX_TAPS - 1))
		|| ((i_q == fh - 8'd1) && (j_q == fw - 8'd1));
	assign emit   = (state_q == S_TAPS) && (!out_valid_q || out_ready);
	assign in_acc = in_valid && in_ready;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			input_size_q  <= INPUT_SIZE_RST;
			filter_size_q <= FILTER_SIZE_RST;
			padding_q     <= PADDING_RST;
			stride_q      <= STRIDE_RST;
			dilation_q    <= DILATION_RST;
			tap_order_q   <= TAP_ORDER_DIRECT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_INPUT_SIZE:      input_size_q  <= cfg_data;
				REG_FILTER_SIZE:     filter_size_q <= cfg_data[15:0];
				REG_PADDING_OFFSETS: padding_q     <= cfg_data[15:0];
				REG_STRIDE_PAIR:     stride_q      <= cfg_data[15:0];
				REG_DILATION_PAIR:   dilation_q    <= cfg_data[15:0];
				REG_TAP_ORDER:       tap_order_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tile_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						tile_cnt_q <= tile_cnt_q + 24'd1;
						step_q     <= '0;
						if (fh != 8'd0 && fw != 8'd0)
							state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4)
						state_q <= S_TAPS;
				end
				S_TAPS: begin
					if (emit && last)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					batch_q <= in_data.batch_index;
					orow_q  <= in_data.out_row & CMASK;
					ocol_q  <= in_data.out_col & CMASK;
					tile_q  <= tile_cnt_q;
					x_q     <= {{(AW-8){padding_q[7]}}, padding_q[7:0]};
					colb_q  <= {{(AW-8){padding_q[15]}}, padding_q[15:8]};
					i_q     <= '0;
					j_q     <= '0;
					cnt_q   <= '0;
				end
			end
			S_SETUP: begin
				if (step_q < 3'd4)
					prod_q <= mul_p;
				case (step_q)
					3'd1: x_q    <= x_q + prod_s;
					3'd2: colb_q <= colb_q + prod_s;
					3'd3: x_q    <= direct ? x_q : x_q + prod_s;
					3'd4: begin
						y_q    <= direct ? colb_q : colb_q + prod_s;
						colb_q <= direct ? colb_q : colb_q + prod_s;
					end
					default: ;
				endcase
			end
			S_TAPS: begin
				if (emit) begin
					out_q.src_batch  <= batch_q;
					out_q.src_row    <= in_image ? (x_q[11:0] & CMASK) : 12'd0;
					out_q.src_col    <= in_image ? (y_q[11:0] & CMASK) : 12'd0;
					out_q.is_padding <= !in_image;
					out_q.tap_index  <= 6'(cnt_q);
					out_q.tile_index <= tile_q;
					out_q.last_tap   <= last;
					cnt_q <= cnt_q + CNT_W'(1);
					if (j_q == fw - 8'd1) begin
						j_q <= '0;
						i_q <= i_q + 8'd1;
						y_q <= colb_q;
						x_q <= direct ? x_q + dr_s : x_q - dr_s;
					end else begin
						j_q <= j_q + 8'd1;
						y_q <= direct ? y_q + dc_s : y_q - dc_s;
					end
				end
			end
			default: ;
		endcase
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAPS |-> cnt_q < CNT_W'(MAX_TAPS))
		else $error("tap count past limit");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAPS |-> (i_q < fh) && (j_q < fw))
		else $error("tap position outside filter");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit && last |=> state_q == S_IDLE && out_valid_q && out_q.last_tap)
		else $error("last tap did not end tile");

	a_tile_inc: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> tile_cnt_q == $past(tile_cnt_q) + 24'd1)
		else $error("tile counter did not advance");

	a_setup_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SETUP && step_q == 3'd4 |=> state_q == S_TAPS && !$past(emit))
		else $error("setup sequence broken");

endmodule

// File: test/tb_im2row_tap_address_generator.sv
module tb_im2row_tap_address_generator;
	import im2row_pkg::*;

	localparam int  CYCLE_LIMIT       = 2000000;
	localparam int  TILE_TARGET       = 380;
	localparam int  QUIET_TAIL        = 60;
	localparam int  SETTLE_CYCLES     = 24;
	localparam int  HOLD_OFF_CYCLES   = 300;
	localparam logic TAP_ORDER_FLIPPED = ~TAP_ORDER_DIRECT;

	class tap_scoreboard;
		logic [23:0] input_size;
		logic [15:0] filter_size;
		logic [15:0] padding_offsets;
		logic [15:0] stride_pair;
		logic [15:0] dilation_pair;
		logic        tap_order;
		logic [23:0] tile_count;
		tap_addr_t   pending_taps[$];
		int          errors;
		int          taps_checked;
		int          pad_taps;
		int          tiles_seen;

		function new();
			input_size      = INPUT_SIZE_RST;
			filter_size     = FILTER_SIZE_RST;
			padding_offsets = PADDING_RST;
			stride_pair     = STRIDE_RST;
			dilation_pair   = DILATION_RST;
			tap_order       = TAP_ORDER_DIRECT;
			tile_count      = '0;
			errors          = 0;
			taps_checked    = 0;
			pad_taps        = 0;
			tiles_seen      = 0;
		endfunction

		function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_INPUT_SIZE:      input_size      = val[23:0];
				REG_FILTER_SIZE:     filter_size     = val[15:0];
				REG_PADDING_OFFSETS: padding_offsets = val[15:0];
				REG_STRIDE_PAIR:     stride_pair     = val[15:0];
				REG_DILATION_PAIR:   dilation_pair   = val[15:0];
				REG_TAP_ORDER:       tap_order       = val[0];
				default: ;
			endcase
		endfunction

		function void note_tile(tile_req_t req);
			int ih, iw, fh, fw, pr, pc, sr, sc, dr, dc;
			int orow, ocol, total, count, ti, tj, x, y;
			bit in_bounds;
			tap_addr_t t;
			ih    = input_size[11:0];
			iw    = input_size[23:12];
			fh    = filter_size[7:0];
			fw    = filter_size[15:8];
			pr    = $signed(padding_offsets[7:0]);
			pc    = $signed(padding_offsets[15:8]);
			sr    = stride_pair[7:0];
			sc    = stride_pair[15:8];
			dr    = dilation_pair[7:0];
			dc    = dilation_pair[15:8];
			orow  = req.out_row;
			ocol  = req.out_col;
			total = fh * fw;
			if (total > MAX_TAPS_DEFAULT)
				total = MAX_TAPS_DEFAULT;
			count = 0;
			for (int i = 0; i < fh && count < total; i++) begin
				for (int j = 0; j < fw && count < total; j++) begin
					ti = tap_order ? i : fh - 1 - i;
					tj = tap_order ? j : fw - 1 - j;
					x  = pr + ti * dr + orow * sr;
					y  = pc + tj * dc + ocol * sc;
					in_bounds    = x >= 0 && x < ih && y >= 0 && y < iw;
					t.src_batch  = req.batch_index;
					t.src_row    = in_bounds ? x[11:0] : 12'd0;
					t.src_col    = in_bounds ? y[11:0] : 12'd0;
					t.is_padding = !in_bounds;
					t.tap_index  = count[5:0];
					t.tile_index = tile_count;
					t.last_tap   = (count == total - 1);
					pending_taps.push_back(t);
					count++;
				end
			end
			tile_count = tile_count + 24'd1;
			tiles_seen++;
		endfunction

		function void check_tap(tap_addr_t got);
			tap_addr_t want;
			taps_checked++;
			if (pending_taps.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected tap item: tile %0d tap %0d row %0d col %0d",
						got.tile_index, got.tap_index, got.src_row, got.src_col);
				return;
			end
			want = pending_taps.pop_front();
			if (want.is_padding)
				pad_taps++;
			if (got.src_batch !== want.src_batch || got.src_row !== want.src_row ||
			    got.src_col !== want.src_col || got.is_padding !== want.is_padding ||
			    got.tap_index !== want.tap_index || got.tile_index !== want.tile_index ||
			    got.last_tap !== want.last_tap) begin
				errors++;
				if (errors <= 10) begin
					$display("tap mismatch, expected: batch %0d row %0d col %0d pad %0b tap %0d tile %0d last %0b",
						want.src_batch, want.src_row, want.src_col, want.is_padding,
						want.tap_index, want.tile_index, want.last_tap);
					$display("              actual:   batch %0d row %0d col %0d pad %0b tap %0d tile %0d last %0b",
						got.src_batch, got.src_row, got.src_col, got.is_padding,
						got.tap_index, got.tile_index, got.last_tap);
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	tile_req_t              in_data;
	logic                   out_valid;
	logic                   out_ready;
	tap_addr_t              out_data;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	tap_scoreboard sb = new();
	int  cycles       = 0;
	int  tiles_sent   = 0;
	int  settings     = 0;
	int  hold_off     = 0;
	bit  tx_stalls    = 1'b1;
	bit  rx_stalls    = 1'b1;

	im2row_tap_address_generator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d taps outstanding",
				cycles, sb.pending_taps.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_tap(out_data);
	end

	initial begin : rx_side
		int   burst;
		logic level;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off > 0) begin
				burst    = hold_off;
				hold_off = 0;
				level    = 1'b0;
			end else if (rx_stalls && $urandom_range(0, 2) == 0) begin
				burst = $urandom_range(1, 16);
				level = 1'b0;
			end else begin
				burst = rx_stalls ? $urandom_range(1, 16) : 1;
				level = 1'b1;
			end
			out_ready <= level;
			repeat (burst - 1) @(negedge clk);
		end
	end

	task automatic send_tile(input logic [7:0] b, input logic [11:0] r, input logic [11:0] c);
		tile_req_t req;
		req.batch_index = b;
		req.out_row     = r;
		req.out_col     = c;
		if (tx_stalls && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		sb.note_tile(req);
		tiles_sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending_taps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// upper bits of the narrow registers carry junk that must be dropped
	task automatic configure(input int ih, input int iw, input int fh, input int fw,
		input int pr, input int pc, input int sr, input int sc, input int dr, input int dc,
		input logic order);
		logic [31:0] junk;
		junk = $urandom();
		drain();
		write_reg(REG_INPUT_SIZE,      {iw[11:0], ih[11:0]});
		write_reg(REG_FILTER_SIZE,     {junk[7:0], fw[7:0], fh[7:0]});
		write_reg(REG_PADDING_OFFSETS, {junk[15:8], pc[7:0], pr[7:0]});
		write_reg(REG_STRIDE_PAIR,     {junk[23:16], sc[7:0], sr[7:0]});
		write_reg(REG_DILATION_PAIR,   {junk[31:24], dc[7:0], dr[7:0]});
		write_reg(REG_TAP_ORDER,       {junk[31:9], order});
		settings++;
	endtask

	function automatic int pick_extent();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 4095;
			2: return $urandom_range(0, 4095);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function automatic int pick_step();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(0, 255);
			default: return $urandom_range(1, 3);
		endcase
	endfunction

	function automatic int pick_filter();
		case ($urandom_range(0, 11))
			0: return 0;
			1: return $urandom_range(0, 255);
			2, 3: return $urandom_range(5, 10);
			default: return $urandom_range(1, 4);
		endcase
	endfunction

	function automatic int pick_pad();
		if ($urandom_range(0, 1))
			return $urandom_range(0, 255) - 128;
		return $urandom_range(0, 6) - 3;
	endfunction

	initial begin : stimulus
		int ih, iw, fh, fw, pr, pc, sr, sc, dr, dc, n, row_hi, col_hi, phase;
		logic order;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset defaults: 1x1 input, 1x1 filter
		send_tile(8'd0, 12'd0, 12'd0);
		send_tile(8'd255, 12'd4095, 12'd4095);

		configure(8, 8, 3, 3, -1, -1, 1, 1, 1, 1, TAP_ORDER_DIRECT);
		send_tile(8'd1, 12'd0, 12'd0);
		send_tile(8'd2, 12'd7, 12'd7);
		send_tile(8'd3, 12'd3, 12'd4);
		configure(8, 8, 3, 3, -1, -1, 1, 1, 1, 1, TAP_ORDER_FLIPPED);
		send_tile(8'd4, 12'd0, 12'd0);
		send_tile(8'd5, 12'd2, 12'd5);

		// more taps than the cap
		configure(4095, 4095, 9, 9, 127, -128, 255, 255, 255, 255, TAP_ORDER_DIRECT);
		send_tile(8'd255, 12'd4095, 12'd4095);
		send_tile(8'd0, 12'd1, 12'd1);
		configure(4095, 4095, 255, 255, -128, 127, 1, 1, 1, 1, TAP_ORDER_FLIPPED);
		send_tile(8'd7, 12'd10, 12'd10);

		// empty filter still advances the tile count
		configure(16, 16, 0, 3, 0, 0, 1, 1, 1, 1, TAP_ORDER_DIRECT);
		send_tile(8'd8, 12'd1, 12'd1);
		send_tile(8'd9, 12'd2, 12'd2);
		configure(16, 16, 3, 0, 0, 0, 1, 1, 1, 1, TAP_ORDER_DIRECT);
		send_tile(8'd10, 12'd3, 12'd3);

		// zero-sized input
		configure(0, 16, 2, 2, 0, 0, 1, 1, 1, 1, TAP_ORDER_DIRECT);
		send_tile(8'd11, 12'd0, 12'd0);
		configure(16, 0, 2, 2, 0, 0, 1, 1, 1, 1, TAP_ORDER_DIRECT);
		send_tile(8'd12, 12'd0, 12'd0);

		// 1D form
		configure(32, 1, 5, 1, -2, 0, 2, 1, 3, 1, TAP_ORDER_DIRECT);
		send_tile(8'd13, 12'd0, 12'd0);
		send_tile(8'd13, 12'd5, 12'd0);
		send_tile(8'd13, 12'd14, 12'd0);

		configure(6, 6, 2, 3, 1, 1, 0, 0, 0, 0, TAP_ORDER_FLIPPED);
		send_tile(8'd200, 12'd4095, 12'd4095);

		phase = 0;
		while (tiles_sent < TILE_TARGET) begin
			ih    = pick_extent();
			iw    = pick_extent();
			fh    = pick_filter();
			fw    = pick_filter();
			pr    = pick_pad();
			pc    = pick_pad();
			sr    = pick_step();
			sc    = pick_step();
			dr    = pick_step();
			dc    = pick_step();
			order = $urandom_range(0, 1);
			if (phase == 0) begin
				ih = 24;
				iw = 24;
				fh = 3;
				fw = 3;
			end
			if (tiles_sent >= TILE_TARGET - QUIET_TAIL) begin
				tx_stalls = 1'b0;
				rx_stalls = 1'b0;
			end
			configure(ih, iw, fh, fw, pr, pc, sr, sc, dr, dc, order);
			if (phase == 0) begin
				tx_stalls = 1'b0;
				hold_off  = HOLD_OFF_CYCLES;
				n         = 20;
			end else begin
				n = (fh * fw > 16) ? $urandom_range(2, 5) : $urandom_range(10, 30);
			end
			row_hi = (ih + 2) / (sr == 0 ? 1 : sr);
			col_hi = (iw + 2) / (sc == 0 ? 1 : sc);
			if (row_hi > 4095)
				row_hi = 4095;
			if (col_hi > 4095)
				col_hi = 4095;
			repeat (n) begin
				if ($urandom_range(0, 6) != 0)
					send_tile($urandom_range(0, 255), $urandom_range(0, row_hi),
						$urandom_range(0, col_hi));
				else
					send_tile($urandom_range(0, 255), $urandom_range(0, 4095),
						$urandom_range(0, 4095));
			end
			if (phase == 0 && tiles_sent < TILE_TARGET - QUIET_TAIL)
				tx_stalls = 1'b1;
			phase++;
		end

		drain();
		repeat (40) @(posedge clk);
		if (sb.pending_taps.size() != 0) begin
			$display("%0d expected tap items never arrived", sb.pending_taps.size());
			sb.errors++;
		end
		$display("ran %0d tiles over %0d register settings, %0d tap items checked (%0d padding)",
			sb.tiles_seen, settings, sb.taps_checked, sb.pad_taps);
		$display("included tap cap, empty filter, zero input, 1D, both tap orders, %0d-cycle hold",
			HOLD_OFF_CYCLES);
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
